FILE: src/bpsc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the bit pattern search core.
// No dependencies; every other file imports this package.
package bpsc_pkg;

  localparam int BYTE_W     = 8;
  localparam int LANES      = 8;
  localparam int LANE_IDX_W = 3;
  localparam int POS_W      = 32;
  localparam int LEN_W      = 7;
  localparam int SEEN_W     = 7;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 1;

  localparam int DEF_MAX_PATTERN_BITS = 64;

  localparam logic [SEEN_W-1:0] SEEN_SAT    = 7'd64;
  localparam logic [LEN_W-1:0]  LEN_RESET   = 7'd1;
  localparam logic [POS_W-1:0]  POS_MAX     = {POS_W{1'b1}};

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BITS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LEN  = 1'd1;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              first_byte;
    logic              last_byte;
  } in_item_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] byte_position;
  } out_item_t;

  // merged lane verdict
  typedef struct packed {
    logic             hit;
    logic [POS_W-1:0] position;
  } match_t;

endpackage

FILE: src/byte_stream_bit_pattern_search_core.sv
`timescale 1ns / 1ps
// Byte stream bit pattern search core, top level.
// An input transfer's result is registered into the output register, or into the skid register when the output is held.
// Throughput: one byte per cycle while in_ready is high; the eight alignment lanes and the merge are combinational.
// in_ready drops only while the skid register holds a second waiting result.
// Reset (rst_n low, synchronous) clears the search state; pattern is 0, length 1.
// Depends on bpsc_pkg, bpsc_lane and bpsc_merge.
module byte_stream_bit_pattern_search_core
  import bpsc_pkg::*;
#(
  parameter int MAX_PATTERN_BITS = DEF_MAX_PATTERN_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int HW = MAX_PATTERN_BITS;

  // configuration registers
  logic [CFG_DATA_W-1:0] pattern_bits_r;
  logic [LEN_W-1:0]      pattern_len_r;

  // search state
  logic [HW-1:0]     hist_r, hist_nxt;
  logic [SEEN_W-1:0] seen_r, seen_nxt;
  logic [POS_W-1:0]  count_r, count_nxt;
  logic              search_done_r, search_done_nxt;

  // output register and skid stage
  logic      out_valid_r, skid_valid_r;
  out_item_t out_data_r, skid_data_r;

  // state as seen by the current byte (first_byte clears it first)
  logic [HW-1:0]     hist_eff;
  logic [SEEN_W-1:0] seen_eff;
  logic [POS_W-1:0]  count_eff;
  logic              done_eff;

  logic [LEN_W-1:0]  len_eff;
  logic [HW-1:0]     mask;
  logic [HW-1:0]     want;
  logic [LANES-1:0]  hits;
  match_t            merged;

  logic              in_fire;
  logic              res_valid;
  out_item_t         res_data;
  logic [SEEN_W:0]   seen_add;

  assign in_ready  = !skid_valid_r;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Clamp the length and build the compare mask once; all lanes share them.
  always_comb begin
    len_eff = (pattern_len_r > LEN_W'(HW)) ? LEN_W'(HW) : pattern_len_r;
    for (int i = 0; i < HW; i++) begin
      mask[i] = (len_eff > LEN_W'(i));
    end
    want = pattern_bits_r[HW-1:0] & mask;
  end

  always_comb begin
    hist_eff  = in_data.first_byte ? '0 : hist_r;
    seen_eff  = in_data.first_byte ? '0 : seen_r;
    count_eff = in_data.first_byte ? '0 : count_r;
    done_eff  = in_data.first_byte ? 1'b0 : search_done_r;
  end

  // Eight lanes, one per bit alignment that the new byte completes.
  for (genvar k = 0; k < LANES; k++) begin : g_lane
    bpsc_lane #(
      .HW   (HW),
      .LANE (k)
    ) u_lane (
      .hist      (hist_eff),
      .data_byte (in_data.data_byte),
      .mask      (mask),
      .want      (want),
      .seen      (seen_eff),
      .len_eff   (len_eff),
      .hit       (hits[k])
    );
  end

  bpsc_merge u_merge (
    .hits    (hits),
    .count   (count_eff),
    .len_eff (len_eff),
    .result  (merged)
  );

  // Next search state and the result this byte causes.
  always_comb begin
    hist_nxt        = hist_eff;
    seen_nxt        = seen_eff;
    count_nxt       = count_eff;
    search_done_nxt = done_eff;
    res_valid       = 1'b0;
    res_data        = '0;
    seen_add        = {1'b0, seen_eff} + (SEEN_W + 1)'(BYTE_W);
    if (done_eff) begin
      // search over: drop the byte
    end else if (len_eff == '0) begin
      // empty pattern matches at byte 0
      search_done_nxt = 1'b1;
      res_valid       = 1'b1;
      res_data.found  = 1'b1;
    end else if (merged.hit) begin
      search_done_nxt        = 1'b1;
      res_valid              = 1'b1;
      res_data.found         = 1'b1;
      res_data.byte_position = merged.position;
    end else begin
      // no match: shift the byte into the history and advance
      hist_nxt  = (hist_eff << BYTE_W) | HW'(in_data.data_byte);
      seen_nxt  = (seen_add > {1'b0, SEEN_SAT}) ? SEEN_SAT : seen_add[SEEN_W-1:0];
      count_nxt = (count_eff < POS_MAX) ? count_eff + 1'b1 : count_eff;
      if (in_data.last_byte) begin
        search_done_nxt = 1'b1;
        res_valid       = 1'b1;
      end
    end
  end

  // Configuration writes; an unknown index is dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_bits_r <= '0;
      pattern_len_r  <= LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PATTERN_BITS: pattern_bits_r <= cfg_data;
        REG_PATTERN_LEN:  pattern_len_r  <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Search state advances on every input transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r        <= '0;
      seen_r        <= '0;
      count_r       <= '0;
      search_done_r <= 1'b0;
    end else if (in_fire) begin
      hist_r        <= hist_nxt;
      seen_r        <= seen_nxt;
      count_r       <= count_nxt;
      search_done_r <= search_done_nxt;
    end
  end

  // Output register plus skid: a new result lands in the output register when it
  // is free or being drained, otherwise it waits in the skid stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_ready) begin
        skid_valid_r <= 1'b0;
      end
    end else if (in_fire && res_valid) begin
      if (!out_valid_r || out_ready) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_ready) begin
        out_data_r <= skid_data_r;
      end
    end else if (in_fire && res_valid) begin
      if (!out_valid_r || out_ready) begin
        out_data_r <= res_data;
      end else begin
        skid_data_r <= res_data;
      end
    end
  end

  // A result waits in the skid stage only behind one in the output register.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds a result while output register is empty");

  // A not-found result carries position zero.
  a_notfound_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.found |-> out_data_r.byte_position == '0)
    else $error("not-found result with nonzero position");

  // Any reported result ends the search.
  a_done_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && res_valid |=> search_done_r)
    else $error("search not marked done after a result");

  // The bit counter never passes its saturation point.
  a_seen_sat: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r <= SEEN_SAT)
    else $error("bits seen above saturation");

endmodule

FILE: src/bpsc_lane.sv
`timescale 1ns / 1ps
// One alignment lane: tests the window that ends at bit BYTE_W-1-LANE of the new byte (its top LANE+1 bits).
// Depends on bpsc_pkg.
module bpsc_lane
  import bpsc_pkg::*;
#(
  parameter int HW   = DEF_MAX_PATTERN_BITS,
  parameter int LANE = 0
) (
  input  logic [HW-1:0]     hist,
  input  logic [BYTE_W-1:0] data_byte,
  input  logic [HW-1:0]     mask,
  input  logic [HW-1:0]     want,
  input  logic [SEEN_W-1:0] seen,
  input  logic [LEN_W-1:0]  len_eff,
  output logic              hit
);

  logic [HW-1:0] window;
  logic          seen_ok;

  always_comb begin
    window  = (hist << (LANE + 1)) | HW'(data_byte >> (BYTE_W - 1 - LANE));
    seen_ok = (({1'b0, seen} + 8'(LANE + 1)) >= {1'b0, len_eff});
    hit     = seen_ok && (((window ^ want) & mask) == '0);
  end

endmodule

FILE: src/bpsc_merge.sv
`timescale 1ns / 1ps
// Merge stage: pick the earliest hitting lane and form the start byte index.
// Depends on bpsc_pkg.
module bpsc_merge
  import bpsc_pkg::*;
(
  input  logic [LANES-1:0] hits,
  input  logic [POS_W-1:0] count,
  input  logic [LEN_W-1:0] len_eff,
  output match_t           result
);

  localparam int SUM_W = POS_W + LANE_IDX_W;

  logic [LANE_IDX_W-1:0] lane_sel;
  logic [SUM_W-1:0]      start_bit;

  always_comb begin
    lane_sel = '0;
    for (int i = LANES - 1; i >= 0; i--) begin
      if (hits[i]) begin
        lane_sel = LANE_IDX_W'(i);
      end
    end
    // first bit of the match = count*8 + lane + 1 - len
    start_bit       = {count, lane_sel} + SUM_W'(1) - SUM_W'(len_eff);
    result.hit      = |hits;
    result.position = start_bit[SUM_W-1:LANE_IDX_W];
  end

endmodule
